### sv/hsvf_pkg.sv
// ----------------------------------------------------------------------------
// hsvf_pkg
// shared types and constants for the per-channel hsv led fader
// ----------------------------------------------------------------------------
package hsvf_pkg;

  typedef enum logic [3:0] {
    REQ_TICK       = 4'd0,
    REQ_NOTE_ON    = 4'd1,
    REQ_NOTE_OFF   = 4'd2,
    REQ_BEND       = 4'd3,
    REQ_RESTORE_BG = 4'd4,
    REQ_CLEAR_LEDS = 4'd5,
    REQ_FULL_RESET = 4'd6,
    REQ_FADE_ALL   = 4'd7,
    REQ_SET_TARGET = 4'd8,
    REQ_SET_BG     = 4'd9
  } req_t;

  localparam logic ADDR_STEP_LIM = 1'b0;
  localparam logic ADDR_BEND_RNG = 1'b1;

  localparam logic [7:0] STEP_LIM_RST = 8'd4;
  localparam logic [3:0] BEND_RNG_RST = 4'd2;
  localparam logic [7:0] SAT_BASE     = 8'd79;

  typedef struct packed {
    logic [7:0] h;
    logic [7:0] s;
    logic [7:0] v;
  } hsv_t;

  // front to back queue entry
  typedef struct packed {
    logic [3:0]  req;
    logic [2:0]  channel;
    logic [6:0]  note;
    logic [15:0] bend;
    hsv_t        col;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK
  } back_state_t;

  // led start for each channel
  function automatic logic [4:0] led_map(input logic [2:0] ch);
    logic [4:0] r;
    case (ch)
      3'd0: r = 5'd12;
      3'd1: r = 5'd16;
      3'd2: r = 5'd8;
      3'd3: r = 5'd20;
      3'd4: r = 5'd4;
      3'd5: r = 5'd24;
      3'd6: r = 5'd0;
      default: r = 5'd28;
    endcase
    return r;
  endfunction

  // rainbow hue floor(n*53/5) for n in 0..23
  function automatic logic [7:0] rainbow_hue(input logic [4:0] n);
    logic [7:0] r;
    case (n)
      5'd0: r = 8'd0;     5'd1: r = 8'd10;    5'd2: r = 8'd21;
      5'd3: r = 8'd31;    5'd4: r = 8'd42;    5'd5: r = 8'd53;
      5'd6: r = 8'd63;    5'd7: r = 8'd74;    5'd8: r = 8'd84;
      5'd9: r = 8'd95;    5'd10: r = 8'd106;  5'd11: r = 8'd116;
      5'd12: r = 8'd127;  5'd13: r = 8'd137;  5'd14: r = 8'd148;
      5'd15: r = 8'd159;  5'd16: r = 8'd169;  5'd17: r = 8'd180;
      5'd18: r = 8'd190;  5'd19: r = 8'd201;  5'd20: r = 8'd212;
      5'd21: r = 8'd222;  5'd22: r = 8'd233;  5'd23: r = 8'd243;
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

### sv/per_channel_hsv_led_fader.sv
// ----------------------------------------------------------------------------
// per_channel_hsv_led_fader
// hsv color keeper and fader for a set of led channels
// ----------------------------------------------------------------------------
// usage:
//   a command is taken when start is high and busy is low; commands with no
//   effect (unused codes, channel out of range) are dropped at the front
//   other commands enter a two entry queue that feeds the back end
//   each result is shown for one cycle with out_valid high; out_last marks
//   the final result of a transaction; the receiver cannot stall
// flow:
//   a single-channel command waits in the queue while the back end is busy,
//   then passes its idle and exec states; its result is registered to the
//   outputs; a tick walks every channel, one per cycle, in the tick state;
//   the back end sequencer sets the rate and pops the queue only in idle
// reset:
//   colors clear to zero, targets become rainbow, fades stop,
//   the fade step limit returns to 4 and the bend range to 2
// ----------------------------------------------------------------------------
module per_channel_hsv_led_fader #(
  parameter int CHANNELS = 8,
  parameter int LEDS_PER_CHANNEL = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  in_req_type,
  input  logic [2:0]  in_channel,
  input  logic [6:0]  in_note,
  input  logic signed [15:0] in_bend,
  input  logic [6:0]  in_color_hue,
  input  logic [6:0]  in_color_sat,
  input  logic [6:0]  in_color_val,
  output logic        out_valid,
  output logic [2:0]  out_channel,
  output logic [4:0]  out_led_start,
  output logic [7:0]  out_hue,
  output logic [7:0]  out_sat,
  output logic [7:0]  out_val,
  output logic        out_clear_all,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hsvf_pkg::*;

  // config registers
  logic [7:0] step_lim_r;
  logic [3:0] bend_rng_r;
  logic       wr_en;
  logic       unused_leds;

  assign unused_leds = (LEDS_PER_CHANNEL > 0);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && unused_leds;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_lim_r <= STEP_LIM_RST;
      bend_rng_r <= BEND_RNG_RST;
    end else if (wr_en) begin
      if (paddr[2] == ADDR_STEP_LIM) step_lim_r <= pwdata[7:0];
      if (paddr[2] == ADDR_BEND_RNG) bend_rng_r <= pwdata[3:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'd0) begin
      if (paddr[2] == ADDR_STEP_LIM) prdata = {24'd0, step_lim_r};
      else                           prdata = {28'd0, bend_rng_r};
    end
  end

  cmd_t cmd_in, q_data;
  logic q_valid, q_pop;

  always_comb begin
    cmd_in.req     = in_req_type;
    cmd_in.channel = in_channel;
    cmd_in.note    = in_note;
    cmd_in.bend    = in_bend;
    cmd_in.col     = '{{in_color_hue, 1'b0}, {in_color_sat, 1'b0}, {in_color_val, 1'b0}};
  end

  hsvf_front #(.CHANNELS(CHANNELS)) u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd_in(cmd_in),
    .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop)
  );

  hsvf_back #(.CHANNELS(CHANNELS)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .step_lim(step_lim_r), .bend_rng(bend_rng_r),
    .out_strobe(out_valid), .out_channel(out_channel), .out_led_start(out_led_start),
    .out_hue(out_hue), .out_sat(out_sat), .out_val(out_val),
    .out_clear_all(out_clear_all), .out_last(out_last)
  );

endmodule

### sv/hsvf_front.sv
// ----------------------------------------------------------------------------
// hsvf_front
// accepts commands, drops ones that do nothing, queues the rest
// ----------------------------------------------------------------------------
module hsvf_front #(
  parameter int CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  hsvf_pkg::cmd_t     cmd_in,
  output logic               q_valid,
  output hsvf_pkg::cmd_t     q_data,
  input  logic               q_pop
);
  import hsvf_pkg::*;

  // two entry queue
  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       keep, push;

  always_comb begin
    keep = 1'b1;
    if (cmd_in.req > 4'(REQ_SET_BG)) begin
      keep = 1'b0;
    end else if (cmd_in.req != 4'(REQ_TICK) && cmd_in.req != 4'(REQ_CLEAR_LEDS) &&
                 cmd_in.req != 4'(REQ_FULL_RESET) && cmd_in.req != 4'(REQ_FADE_ALL) &&
                 32'(cmd_in.channel) >= CHANNELS) begin
      keep = 1'b0;
    end
  end

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign q_data  = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push  ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= cmd_in;
    end
  end

endmodule

### sv/hsvf_back.sv
// ----------------------------------------------------------------------------
// hsvf_back
// carries out queued commands, walks channels one per cycle on a tick
// ----------------------------------------------------------------------------
module hsvf_back #(
  parameter int CHANNELS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  hsvf_pkg::cmd_t     q_data,
  output logic               q_pop,
  input  logic [7:0]         step_lim,
  input  logic [3:0]         bend_rng,
  output logic               out_strobe,
  output logic [2:0]         out_channel,
  output logic [4:0]         out_led_start,
  output logic [7:0]         out_hue,
  output logic [7:0]         out_sat,
  output logic [7:0]         out_val,
  output logic               out_clear_all,
  output logic               out_last
);
  import hsvf_pkg::*;

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  hsv_t cur_r [CHANNELS];
  hsv_t bg_r  [CHANNELS];
  hsv_t tgt_r [CHANNELS];
  hsv_t note_r[CHANNELS];
  logic [CHANNELS-1:0] rainbow_r, fading_r;

  back_state_t st_r, st_nxt;
  cmd_t        cmd_r;
  logic [CW:0] idx_r, idx_nxt;
  logic [CHANNELS-1:0] pend_r, pend_nxt;   // fading set snapshot for this tick
  logic signed [31:0]  prod_r;              // 255*range*bend, registered
  logic signed [20:0]  bo;                  // bend times range

  logic        o_stb_r, o_clr_r, o_last_r;
  logic [2:0]  o_ch_r;
  hsv_t        o_col_r;

  logic [CW-1:0] ch;
  logic [CW-1:0] tix;
  assign ch  = cmd_r.channel[CW-1:0];
  assign tix = idx_r[CW-1:0];

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (q_valid) begin
        st_nxt = (q_data.req == 4'(REQ_TICK)) ? ST_TICK : ST_EXEC;
      end
      ST_EXEC: st_nxt = ST_IDLE;
      ST_TICK: if (32'(idx_r) == CHANNELS - 1) begin
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign q_pop   = (st_r == ST_IDLE) && q_valid;
  assign idx_nxt = (st_r == ST_TICK) ? idx_r + 1'b1 : '0;

  always_comb begin
    pend_nxt = pend_r;
    if (q_pop) begin
      pend_nxt = fading_r;
    end else if (st_r == ST_TICK) begin
      pend_nxt[tix] = 1'b0;
    end
  end

  // fade step of one component
  function automatic logic [8:0] step(input logic [7:0] c, input logic [7:0] t,
                                      input logic [7:0] sp);
    logic [8:0] r;
    if (c > t && (c - t) > sp)      r = {1'b1, c - sp};
    else if (t > c && (t - c) > sp) r = {1'b1, c + sp};
    else                             r = {1'b0, t};
    return r;
  endfunction

  // remainder by three of a 4-bit value
  function automatic logic [1:0] mod3(input logic [3:0] x);
    logic [3:0] r;
    r = x;
    if (r >= 4'd12) r = r - 4'd12;
    if (r >= 4'd6)  r = r - 4'd6;
    if (r >= 4'd3)  r = r - 4'd3;
    return r[1:0];
  endfunction

  // bend and pick color
  hsv_t       pick;
  hsv_t       bent;
  logic [3:0] n12;
  logic [4:0] n24;
  logic signed [31:0] num;
  logic signed [31:0] q;
  always_comb begin
    // note mod 24 from the upper bits mod 3 and the low three bits
    n24 = {mod3(cmd_r.note[6:3]), cmd_r.note[2:0]};
    n12 = (n24 >= 5'd12) ? 4'(n24 - 5'd12) : n24[3:0];
    if (rainbow_r[ch]) begin
      pick = '{rainbow_hue(n24), 8'd255, 8'd255};
    end else if (tgt_r[ch].s == 8'd2 && tgt_r[ch].v == 8'd2) begin
      pick = '{tgt_r[ch].h, 8'({n12, 4'd0}) + SAT_BASE, 8'd255};
    end else begin
      pick = tgt_r[ch];
    end
    num  = $signed({19'd0, note_r[ch].h, 5'd0} <<< 8) + prod_r;
    // truncating division by 8192
    q    = (num < 0) ? -((-num) >>> 13) : (num >>> 13);
    bent = '{q[7:0], note_r[ch].s, note_r[ch].v};
  end

  // tick step for current channel
  hsv_t       tk_col;
  logic       tk_moved;
  logic [8:0] sh, ss, sv;
  always_comb begin
    tk_col = cur_r[tix];
    sh = step(cur_r[tix].h, bg_r[tix].h, step_lim);
    ss = step(cur_r[tix].s, bg_r[tix].s, step_lim);
    sv = step(cur_r[tix].v, bg_r[tix].v, step_lim);
    tk_col.v = sv[7:0];
    if (bg_r[tix].v != 8'd0) begin
      tk_col.h = sh[7:0];
      tk_col.s = ss[7:0];
    end
    if (!sv[8] && bg_r[tix].v == 8'd0) begin
      tk_col.h = bg_r[tix].h;
      tk_col.s = bg_r[tix].s;
    end
    tk_moved = sv[8] || (bg_r[tix].v != 8'd0 && (sh[8] || ss[8]));
  end

  logic more_after;
  always_comb begin
    more_after = 1'b0;
    for (int i = 0; i < CHANNELS; i++) begin
      if (pend_r[i] && i > 32'(idx_r)) more_after = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      idx_r     <= '0;
      pend_r    <= '0;
      rainbow_r <= '1;
      fading_r  <= '0;
      o_stb_r   <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        cur_r[i]  <= '0;
        bg_r[i]   <= '0;
        tgt_r[i]  <= '0;
        note_r[i] <= '0;
      end
    end else begin
      st_r    <= st_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
      o_stb_r <= 1'b0;
      case (st_r)
        ST_EXEC: begin
          case (cmd_r.req)
            4'(REQ_NOTE_ON): begin
              cur_r[ch] <= pick; note_r[ch] <= pick; fading_r[ch] <= 1'b0;
              o_stb_r <= 1'b1;
            end
            4'(REQ_NOTE_OFF): fading_r[ch] <= 1'b1;
            4'(REQ_BEND): if (note_r[ch].s != 8'd0) begin
              cur_r[ch] <= bent; fading_r[ch] <= 1'b0; o_stb_r <= 1'b1;
            end
            4'(REQ_RESTORE_BG): begin
              cur_r[ch] <= bg_r[ch]; fading_r[ch] <= 1'b0; o_stb_r <= 1'b1;
            end
            4'(REQ_CLEAR_LEDS): o_stb_r <= 1'b1;
            4'(REQ_FULL_RESET): begin
              rainbow_r <= '1; o_stb_r <= 1'b1;
              for (int i = 0; i < CHANNELS; i++) bg_r[i] <= '0;
            end
            4'(REQ_FADE_ALL): fading_r <= '1;
            4'(REQ_SET_TARGET): begin
              tgt_r[ch] <= cmd_r.col; rainbow_r[ch] <= 1'b0;
            end
            4'(REQ_SET_BG): begin
              bg_r[ch] <= cmd_r.col; fading_r[ch] <= 1'b1;
            end
            default: ;
          endcase
        end
        ST_TICK: if (pend_r[tix]) begin
          cur_r[tix] <= tk_col;
          if (!tk_moved) fading_r[tix] <= 1'b0;
          o_stb_r <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign bo = $signed(q_data.bend) * $signed({1'b0, bend_rng});

  // payload registers
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd_r  <= q_data;
      // times 255 as a shift and subtract
      prod_r <= (32'(bo) <<< 8) - 32'(bo);
    end
    o_clr_r  <= 1'b0;
    o_last_r <= 1'b1;
    o_ch_r   <= 3'(ch);
    o_col_r  <= '0;
    case (st_r)
      ST_EXEC: begin
        case (cmd_r.req)
          4'(REQ_NOTE_ON):    o_col_r <= pick;
          4'(REQ_BEND):       o_col_r <= bent;
          4'(REQ_RESTORE_BG): o_col_r <= bg_r[ch];
          4'(REQ_CLEAR_LEDS), 4'(REQ_FULL_RESET): begin
            o_clr_r <= 1'b1; o_ch_r <= 3'd0;
          end
          default: ;
        endcase
      end
      ST_TICK: begin
        o_ch_r   <= 3'(tix);
        o_col_r  <= tk_col;
        o_last_r <= !more_after;
      end
      default: ;
    endcase
  end

  assign out_strobe    = o_stb_r;
  assign out_channel   = o_ch_r;
  assign out_led_start = o_clr_r ? 5'd0 : led_map(o_ch_r);
  assign out_hue       = o_col_r.h;
  assign out_sat       = o_col_r.s;
  assign out_val       = o_col_r.v;
  assign out_clear_all = o_clr_r;
  assign out_last      = o_last_r;

endmodule
